// ===== sv/gshift_pkg.sv =====
// Shared types, codes and the phase mapping of the gear shift sequencer.
`timescale 1ns / 1ps

package gshift_pkg;

  typedef enum logic [1:0] {
    REG_PRESSURE_THR = 2'd0,
    REG_ACT_TIME     = 2'd1,
    REG_RPM_WINDOW   = 2'd2,
    REG_DELTA_THR    = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] ACT_REST = 2'd0;
  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_PULL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DN_SAMPLE,
    ST_DN_PRESS,
    ST_DN_ACT_START,
    ST_DN_ACT_HOLD,
    ST_DN_CHECK,
    ST_DN_DONE,
    ST_UP_SAMPLE,
    ST_UP_ACT_START,
    ST_UP_ACT_HOLD,
    ST_UP_CHECK,
    ST_UP_DONE
  } state_t;

  function automatic logic [2:0] phase_of(state_t st);
    logic [2:0] ph;
    case (st)
      ST_IDLE:         ph = 3'd0;
      ST_DN_SAMPLE:    ph = 3'd1;
      ST_DN_PRESS:     ph = 3'd2;
      ST_DN_ACT_START: ph = 3'd3;
      ST_DN_ACT_HOLD:  ph = 3'd4;
      ST_DN_CHECK:     ph = 3'd5;
      ST_DN_DONE:      ph = 3'd6;
      ST_UP_SAMPLE:    ph = 3'd1;
      ST_UP_ACT_START: ph = 3'd2;
      ST_UP_ACT_HOLD:  ph = 3'd3;
      ST_UP_CHECK:     ph = 3'd4;
      ST_UP_DONE:      ph = 3'd5;
      default:         ph = 3'd0;
    endcase
    return ph;
  endfunction

endpackage

// ===== sv/gearshift_sequencer.sv =====
// Paddle-driven gear shift sequencer: clutch, actuator and rpm check per control tick.
// The result of an item is registered and valid in the cycle after it is accepted.
// Throughput: one item per cycle while results are taken, set by the single state update per accepted item.
// The result register frees as its item is taken, so input and output may move together.
// Reset (rst, synchronous, active high) clears the sequence state, sets the gear to one,
// and loads the register defaults 512, 50, 200 and 10.
`timescale 1ns / 1ps

module gearshift_sequencer import gshift_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        down_paddle,
  input  logic        up_paddle,
  input  logic [7:0]  engine_rpm,
  input  logic [9:0]  clutch_pressure,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        clutch_engage,
  output logic [1:0]  actuator_cmd,
  output logic [2:0]  shift_phase,
  output logic [7:0]  gear_now,
  output logic [7:0]  failed_tries,
  output logic [7:0]  rpm_change,
  output logic        shifting
);

  logic [9:0]  pressure_threshold;
  logic [15:0] actuation_time_ms;
  logic [15:0] rpm_window_ms;
  logic [7:0]  rpm_delta_threshold;

  state_t          state, state_next, work;
  logic [7:0]      gear, gear_next;
  logic [7:0]      fail_count, fail_count_next;
  logic [7:0]      delta_rpm, delta_rpm_next;
  logic [7:0]      start_rpm, start_rpm_next;
  logic [TIME_WIDTH-1:0] rpm_start_time, rpm_start_time_next;
  logic [TIME_WIDTH-1:0] act_start_time, act_start_time_next;
  logic            clutch_next;
  logic [1:0]      act_next;

  logic [TIME_WIDTH-1:0] now, act_elapsed, rpm_elapsed;
  logic            act_done, window_open;
  logic            accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  assign now         = TIME_WIDTH'(time_ms);
  assign act_elapsed = now - act_start_time;
  assign rpm_elapsed = now - rpm_start_time;
  assign act_done    = act_elapsed >= TIME_WIDTH'(actuation_time_ms);
  assign window_open = rpm_elapsed < TIME_WIDTH'(rpm_window_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_threshold  <= 10'd512;
      actuation_time_ms   <= 16'd50;
      rpm_window_ms       <= 16'd200;
      rpm_delta_threshold <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PRESSURE_THR: pressure_threshold  <= cfg_data[9:0];
        REG_ACT_TIME:     actuation_time_ms   <= cfg_data;
        REG_RPM_WINDOW:   rpm_window_ms       <= cfg_data;
        REG_DELTA_THR:    rpm_delta_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    work = state;
    if (state == ST_IDLE) begin
      if (down_paddle) begin
        work = ST_DN_SAMPLE;
      end else if (up_paddle) begin
        work = ST_UP_SAMPLE;
      end
    end

    state_next          = work;
    gear_next           = gear;
    fail_count_next     = fail_count;
    delta_rpm_next      = delta_rpm;
    start_rpm_next      = start_rpm;
    rpm_start_time_next = rpm_start_time;
    act_start_time_next = act_start_time;
    clutch_next         = 1'b0;
    act_next            = ACT_REST;

    case (work)
      ST_DN_SAMPLE: begin
        start_rpm_next      = engine_rpm;
        rpm_start_time_next = now;
        clutch_next         = 1'b1;
        state_next          = ST_DN_PRESS;
      end
      ST_DN_PRESS: begin
        clutch_next = 1'b1;
        if (clutch_pressure >= pressure_threshold) begin
          state_next = ST_DN_ACT_START;
        end
      end
      ST_DN_ACT_START: begin
        clutch_next         = 1'b1;
        act_next            = ACT_PULL;
        act_start_time_next = now;
        state_next          = ST_DN_ACT_HOLD;
      end
      ST_DN_ACT_HOLD: begin
        clutch_next = 1'b1;
        act_next    = ACT_PULL;
        if (act_done) begin
          state_next = ST_DN_CHECK;
        end
      end
      ST_DN_CHECK: begin
        if (engine_rpm > start_rpm) begin
          delta_rpm_next = engine_rpm - start_rpm;
        end
        if (!window_open) begin
          state_next      = ST_DN_SAMPLE;
          fail_count_next = fail_count + 8'd1;
        end else if (delta_rpm_next >= rpm_delta_threshold) begin
          state_next = ST_DN_DONE;
        end
      end
      ST_DN_DONE: begin
        state_next      = ST_IDLE;
        gear_next       = gear - 8'd1;
        fail_count_next = 8'd0;
        delta_rpm_next  = 8'd0;
      end
      ST_UP_SAMPLE: begin
        start_rpm_next      = engine_rpm;
        rpm_start_time_next = now;
        state_next          = ST_UP_ACT_START;
      end
      ST_UP_ACT_START: begin
        act_next            = ACT_PUSH;
        act_start_time_next = now;
        state_next          = ST_UP_ACT_HOLD;
      end
      ST_UP_ACT_HOLD: begin
        act_next = ACT_PUSH;
        if (act_done) begin
          state_next = ST_UP_CHECK;
        end
      end
      ST_UP_CHECK: begin
        if (start_rpm > engine_rpm) begin
          delta_rpm_next = start_rpm - engine_rpm;
        end
        if (!window_open) begin
          state_next      = ST_UP_SAMPLE;
          fail_count_next = fail_count + 8'd1;
        end else if (delta_rpm_next >= rpm_delta_threshold) begin
          state_next = ST_UP_DONE;
        end
      end
      ST_UP_DONE: begin
        state_next      = ST_IDLE;
        gear_next       = gear + 8'd1;
        fail_count_next = 8'd0;
        delta_rpm_next  = 8'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      gear           <= 8'd1;
      fail_count     <= 8'd0;
      delta_rpm      <= 8'd0;
      start_rpm      <= 8'd0;
      rpm_start_time <= '0;
      act_start_time <= '0;
      clutch_engage  <= 1'b0;
      actuator_cmd   <= ACT_REST;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        state          <= state_next;
        gear           <= gear_next;
        fail_count     <= fail_count_next;
        delta_rpm      <= delta_rpm_next;
        start_rpm      <= start_rpm_next;
        rpm_start_time <= rpm_start_time_next;
        act_start_time <= act_start_time_next;
        clutch_engage  <= clutch_next;
        actuator_cmd   <= act_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign shift_phase  = phase_of(state);
  assign gear_now     = gear;
  assign failed_tries = fail_count;
  assign rpm_change   = delta_rpm;
  assign shifting     = state != ST_IDLE;

  a_down_done_steps_gear: assert property (@(posedge clk) disable iff (rst)
    (accept && state == ST_DN_DONE) |=> gear_now == $past(gear_now) - 8'd1)
    else $error("completed downshift did not step the gear down");

  a_push_without_clutch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && actuator_cmd == ACT_PUSH) |-> !clutch_engage)
    else $error("upshift push issued with the clutch engaged");

  a_idle_outputs_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !shifting) |-> (actuator_cmd == ACT_REST && !clutch_engage))
    else $error("actuator or clutch active while no shift is running");

  a_fail_count_moves_on_item: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(failed_tries))
    else $error("failed attempt count changed without an accepted item");

endmodule

// ===== test/tb_gearshift_sequencer.sv =====
// Self-checking testbench for the gear shift sequencer: directed ticks, then random ticks.
`timescale 1ns / 1ps

module tb_gearshift_sequencer;
  import gshift_pkg::*;

  localparam logic [2:0] PH_IDLE         = 3'd0;
  localparam logic [2:0] PH_SAMPLE       = 3'd1;
  localparam logic [2:0] PH_DN_PRESS     = 3'd2;
  localparam logic [2:0] PH_DN_ACT_START = 3'd3;
  localparam logic [2:0] PH_DN_ACT_HOLD  = 3'd4;
  localparam logic [2:0] PH_DN_CHECK     = 3'd5;
  localparam logic [2:0] PH_DN_DONE      = 3'd6;
  localparam logic [2:0] PH_UP_ACT_START = 3'd2;
  localparam logic [2:0] PH_UP_ACT_HOLD  = 3'd3;
  localparam logic [2:0] PH_UP_CHECK     = 3'd4;
  localparam logic [2:0] PH_UP_DONE      = 3'd5;

  typedef struct packed {
    logic       clutch;
    logic [1:0] act;
    logic [2:0] phase;
    logic [7:0] gear;
    logic [7:0] fails;
    logic [7:0] rpm_chg;
    logic       busy;
  } shift_out_t;

  typedef struct {
    bit          dn;
    bit          up;
    logic [7:0]  rpm;
    logic [9:0]  press;
    logic [31:0] t;
    bit          pinned;
    shift_out_t  res;
  } tick_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_addr = REG_PRESSURE_THR;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        down_paddle = 1'b0;
  logic        up_paddle = 1'b0;
  logic [7:0]  engine_rpm = '0;
  logic [9:0]  clutch_pressure = '0;
  logic [31:0] time_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        clutch_engage;
  logic [1:0]  actuator_cmd;
  logic [2:0]  shift_phase;
  logic [7:0]  gear_now;
  logic [7:0]  failed_tries;
  logic [7:0]  rpm_change;
  logic        shifting;

  gearshift_sequencer dut (.*);

  always #5 clk = ~clk;

  // Shadow of the configuration and of the sequence state.
  logic [9:0]  c_press_thr = 10'd512;
  logic [15:0] c_act_time = 16'd50;
  logic [15:0] c_window = 16'd200;
  logic [7:0]  c_delta_thr = 8'd10;
  logic [2:0]  m_phase = PH_IDLE;
  logic        m_busy = 1'b0;
  logic        m_down = 1'b0;
  logic        m_up = 1'b0;
  logic [7:0]  m_gear = 8'd1;
  logic [7:0]  m_fails = '0;
  logic [7:0]  m_delta = '0;
  logic [7:0]  m_start_rpm = '0;
  logic [31:0] m_rpm_t0 = '0;
  logic [31:0] m_act_t0 = '0;

  shift_out_t pending_shift_outputs[$];
  logic       pin_on = 1'b0;
  shift_out_t pin_res = '0;
  int errors = 0;
  int results_seen = 0;
  int items_taken = 0;
  int downshifts_done = 0;
  int upshifts_done = 0;
  int windows_expired = 0;
  int settings_run = 1;
  int send_calm = 0;
  int recv_calm = 0;
  logic [31:0] clock_ms;
  int rpm_level;
  int rpm_dir;

  task automatic judge_rpm(input logic [7:0] rpm, input logic [31:0] now, input logic down,
                           input logic [2:0] success_phase);
    logic [31:0] el;
    if (down && rpm > m_start_rpm) m_delta = rpm - m_start_rpm;
    if (!down && m_start_rpm > rpm) m_delta = m_start_rpm - rpm;
    el = now - m_rpm_t0;
    if (el < {16'd0, c_window}) begin
      if (m_delta >= c_delta_thr) m_phase = success_phase;
    end else begin
      m_phase = PH_SAMPLE;
      m_fails = m_fails + 8'd1;
      windows_expired++;
    end
  endtask

  task automatic end_shift(input logic down);
    m_phase = PH_IDLE;
    m_busy = 1'b0;
    m_down = 1'b0;
    m_up = 1'b0;
    m_delta = '0;
    m_fails = '0;
    if (down) begin
      m_gear = m_gear - 8'd1;
      downshifts_done++;
    end else begin
      m_gear = m_gear + 8'd1;
      upshifts_done++;
    end
  endtask

  task automatic predict_shift_tick(input logic dn, input logic up, input logic [7:0] rpm,
                                    input logic [9:0] press, input logic [31:0] now,
                                    output shift_out_t res);
    logic [31:0] el;
    res = '0;
    res.act = ACT_REST;
    el = now - m_act_t0;
    if (!m_busy && dn) begin
      m_busy = 1'b1; m_down = 1'b1; m_up = 1'b0; m_phase = PH_SAMPLE;
    end else if (!m_busy && up) begin
      m_busy = 1'b1; m_down = 1'b0; m_up = 1'b1; m_phase = PH_SAMPLE;
    end
    if (m_busy && m_down) begin
      case (m_phase)
        PH_SAMPLE: begin
          m_start_rpm = rpm;
          m_rpm_t0 = now;
          res.clutch = 1'b1;
          m_phase = PH_DN_PRESS;
        end
        PH_DN_PRESS: begin
          res.clutch = 1'b1;
          if (press >= c_press_thr) m_phase = PH_DN_ACT_START;
        end
        PH_DN_ACT_START: begin
          res.clutch = 1'b1;
          res.act = ACT_PULL;
          m_act_t0 = now;
          m_phase = PH_DN_ACT_HOLD;
        end
        PH_DN_ACT_HOLD: begin
          res.clutch = 1'b1;
          res.act = ACT_PULL;
          if (el >= {16'd0, c_act_time}) m_phase = PH_DN_CHECK;
        end
        PH_DN_CHECK: judge_rpm(rpm, now, 1'b1, PH_DN_DONE);
        PH_DN_DONE: end_shift(1'b1);
        default: ;
      endcase
    end else if (m_busy && m_up) begin
      case (m_phase)
        PH_SAMPLE: begin
          m_start_rpm = rpm;
          m_rpm_t0 = now;
          m_phase = PH_UP_ACT_START;
        end
        PH_UP_ACT_START: begin
          res.act = ACT_PUSH;
          m_act_t0 = now;
          m_phase = PH_UP_ACT_HOLD;
        end
        PH_UP_ACT_HOLD: begin
          res.act = ACT_PUSH;
          if (el >= {16'd0, c_act_time}) m_phase = PH_UP_CHECK;
        end
        PH_UP_CHECK: judge_rpm(rpm, now, 1'b0, PH_UP_DONE);
        PH_UP_DONE: end_shift(1'b0);
        default: ;
      endcase
    end
    res.phase = m_phase;
    res.gear = m_gear;
    res.fails = m_fails;
    res.rpm_chg = m_delta;
    res.busy = m_busy;
  endtask

  // Results are checked before the new item is predicted, so a result and an item
  // taken at the same edge never pair up with each other.
  always @(posedge clk) begin
    shift_out_t got;
    shift_out_t want;
    shift_out_t calc;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{clutch_engage, actuator_cmd, shift_phase, gear_now, failed_tries,
                rpm_change, shifting};
        results_seen++;
        if (pending_shift_outputs.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result %0d: %p", results_seen, got);
        end else begin
          want = pending_shift_outputs.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("Mismatch on result %0d:", results_seen);
              $display("  expected clutch %0d act %0d phase %0d gear %0d fails %0d chg %0d busy %0d",
                       want.clutch, want.act, want.phase, want.gear, want.fails,
                       want.rpm_chg, want.busy);
              $display("  actual   clutch %0d act %0d phase %0d gear %0d fails %0d chg %0d busy %0d",
                       got.clutch, got.act, got.phase, got.gear, got.fails,
                       got.rpm_chg, got.busy);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_shift_tick(down_paddle, up_paddle, engine_rpm, clutch_pressure, time_ms, calc);
        pending_shift_outputs.push_back(pin_on ? pin_res : calc);
        items_taken++;
      end
    end
  end

  function automatic int draw_gap(inout int calm);
    int gap;
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 30);
    end
    return gap;
  endfunction

  task automatic send_tick(input tick_row_t row);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    down_paddle <= row.dn;
    up_paddle <= row.up;
    engine_rpm <= row.rpm;
    clutch_pressure <= row.press;
    time_ms <= row.t;
    pin_on <= row.pinned;
    pin_res <= row.res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic tick_row_t tick(bit dn, bit up, logic [7:0] rpm, logic [9:0] press,
                                     logic [31:0] t);
    tick_row_t row;
    row = '{dn, up, rpm, press, t, 1'b0, '0};
    return row;
  endfunction

  task automatic run_random(input int count);
    tick_row_t row;
    int r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) rpm_dir = -rpm_dir;
      r = $urandom_range(0, 99);
      if (r < 75) rpm_level += rpm_dir * int'($urandom_range(0, 9));
      else if (r < 90) rpm_level += int'($urandom_range(0, 20)) - 10;
      else rpm_level = $urandom_range(0, 255);
      if (rpm_level < 0) rpm_level = 0;
      if (rpm_level > 255) rpm_level = 255;
      r = $urandom_range(0, 99);
      if (r < 75) clock_ms += $urandom_range(0, 25);
      else if (r < 90) clock_ms += $urandom_range(0, 300);
      else if (r < 97) clock_ms += $urandom_range(0, 70000);
      else clock_ms = $urandom;
      row = tick($urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0, rpm_level[7:0],
                 10'd0, clock_ms);
      if ($urandom_range(0, 99) < 40) row.press = 10'($urandom_range(0, 1023));
      else row.press = 10'($urandom_range(c_press_thr, 1023));
      send_tick(row);
    end
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_PRESSURE_THR: c_press_thr = val[9:0];
      REG_ACT_TIME:     c_act_time = val;
      REG_RPM_WINDOW:   c_window = val;
      REG_DELTA_THR:    c_delta_thr = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] thr, input logic [15:0] act,
                               input logic [15:0] win, input logic [15:0] delta);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_shift_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    put_reg(REG_PRESSURE_THR, thr);
    put_reg(REG_ACT_TIME, act);
    put_reg(REG_RPM_WINDOW, win);
    put_reg(REG_DELTA_THR, delta);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = draw_gap(recv_calm);
      if (results_seen >= 250 && results_seen < 260) gap = 60;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    tick_row_t plan[$];
    plan.push_back('{1'b0, 1'b0, 8'd0, 10'd0, 32'd0, 1'b1,
                     '{1'b0, ACT_REST, PH_IDLE, 8'd1, 8'd0, 8'd0, 1'b0}});
    // Both paddles at once: the downshift wins and its first phase runs at once.
    plan.push_back('{1'b1, 1'b1, 8'd100, 10'd0, 32'd1000, 1'b1,
                     '{1'b1, ACT_REST, PH_DN_PRESS, 8'd1, 8'd0, 8'd0, 1'b1}});
    plan.push_back(tick(1'b0, 1'b1, 8'd100, 10'd511, 32'd1005));
    plan.push_back(tick(1'b0, 1'b0, 8'd100, 10'd1023, 32'd1008));
    plan.push_back(tick(1'b0, 1'b0, 8'd100, 10'd0, 32'd1010));
    plan.push_back(tick(1'b0, 1'b0, 8'd100, 10'd0, 32'd1059));
    plan.push_back(tick(1'b0, 1'b0, 8'd100, 10'd0, 32'd1060));
    plan.push_back(tick(1'b0, 1'b0, 8'd105, 10'd0, 32'd1100));
    plan.push_back(tick(1'b1, 1'b0, 8'd90, 10'd0, 32'd1120));
    plan.push_back(tick(1'b0, 1'b0, 8'd120, 10'd0, 32'd1150));
    plan.push_back('{1'b0, 1'b0, 8'd120, 10'd0, 32'd1160, 1'b1,
                     '{1'b0, ACT_REST, PH_IDLE, 8'd0, 8'd0, 8'd0, 1'b0}});
    // Upshift across the wrap of the millisecond time, with one expired window.
    plan.push_back(tick(1'b0, 1'b1, 8'd255, 10'd1023, 32'hFFFF_FFF0));
    plan.push_back(tick(1'b0, 1'b0, 8'd255, 10'd0, 32'hFFFF_FFF8));
    plan.push_back(tick(1'b0, 1'b0, 8'd255, 10'd0, 32'h0000_0029));
    plan.push_back(tick(1'b0, 1'b0, 8'd255, 10'd0, 32'h0000_002A));
    plan.push_back(tick(1'b0, 1'b0, 8'd250, 10'd0, 32'h0000_0040));
    plan.push_back(tick(1'b0, 1'b1, 8'd255, 10'd0, 32'h0000_00B8));
    plan.push_back(tick(1'b0, 1'b0, 8'd200, 10'd0, 32'h0000_00C0));
    plan.push_back(tick(1'b0, 1'b0, 8'd200, 10'd0, 32'h0000_00C1));
    plan.push_back(tick(1'b0, 1'b0, 8'd200, 10'd0, 32'h0000_00F3));
    plan.push_back(tick(1'b0, 1'b0, 8'd0, 10'd0, 32'h0000_0100));
    plan.push_back(tick(1'b1, 1'b0, 8'd0, 10'd0, 32'h0000_0101));
    plan.push_back(tick(1'b0, 1'b0, 8'd255, 10'd1023, 32'hFFFF_FFFF));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) send_tick(plan[i]);

    clock_ms = 32'h0000_1000;
    rpm_level = 128;
    rpm_dir = 1;
    run_random(150);
    apply_setting(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(80);
    apply_setting(16'd1023, 16'd65535, 16'd65535, 16'd255);
    run_random(80);
    apply_setting(16'd300, 16'd20, 16'd150, 16'd5);
    run_random(200);
    apply_setting(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 100)),
                  16'($urandom_range(50, 400)), 16'($urandom_range(0, 30)));
    run_random(200);

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_shift_outputs.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Checked %0d results from %0d ticks under %0d register settings.",
             results_seen, items_taken, settings_run);
    $display("Shifts completed: %0d down, %0d up; rpm windows expired: %0d.",
             downshifts_done, upshifts_done, windows_expired);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches in total.", errors);
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", pending_shift_outputs.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
